// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/dara_pkg.sv =====
// ----------------------------------------------------------------------------
// dara_pkg
// Types and constants of the Banker's-algorithm allocator.
// ----------------------------------------------------------------------------
package dara_pkg;

  localparam int CUSTOMERS = 8;
  localparam int RESOURCES = 4;
  localparam int CIDX_W    = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
  localparam int WORK_W    = 8 + $clog2(CUSTOMERS + 1);

  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CLAIM   = 2'd2;

  localparam logic [2:0] STAT_DONE    = 3'd0;
  localparam logic [2:0] STAT_NEED    = 3'd1;
  localparam logic [2:0] STAT_AVAIL   = 3'd2;
  localparam logic [2:0] STAT_UNSAFE  = 3'd3;
  localparam logic [2:0] STAT_HELD    = 3'd4;
  localparam logic [2:0] STAT_REFUSED = 3'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] customer;
    logic [7:0] amount_0;
    logic [7:0] amount_1;
    logic [7:0] amount_2;
    logic [7:0] amount_3;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] avail_0;
    logic [7:0] avail_1;
    logic [7:0] avail_2;
    logic [7:0] avail_3;
  } result_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_SETMAX
  } op_code_t;

  typedef struct packed {
    op_code_t                    code;
    logic [CIDX_W-1:0]           sel;
    logic                        clr_done;
    logic [RESOURCES-1:0][7:0]   amt;
  } cell_op_t;

  typedef struct packed {
    logic                            valid;
    logic                            progress;
    logic [RESOURCES-1:0][WORK_W-1:0] work;
  } token_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_LAUNCH,
    S_RUN,
    S_RESP
  } fsm_state_t;

endpackage

// ===== rtl/core/dara_cell.sv =====
// ----------------------------------------------------------------------------
// dara_cell
// One customer: claim and held units, finish flag, one safety-check stage.
// ----------------------------------------------------------------------------
module dara_cell import dara_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [CIDX_W-1:0]         id,
  input  cell_op_t                  op,
  input  token_t                    tok_in,
  output token_t                    tok_out,
  output logic [RESOURCES-1:0][7:0] max_claim,
  output logic [RESOURCES-1:0][7:0] held_units,
  output logic                      done
);

  logic fits;
  logic [7:0] need;

  always_comb begin
    fits = ~done;
    need = '0;
    for (int r = 0; r < RESOURCES; r++) begin
      need = (max_claim[r] > held_units[r]) ? max_claim[r] - held_units[r] : 8'd0;
      if (WORK_W'(need) > tok_in.work[r]) fits = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_claim     <= '0;
      held_units    <= '0;
      done          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      if (op.sel == id) begin
        case (op.code)
          OP_ADD: begin
            for (int r = 0; r < RESOURCES; r++) held_units[r] <= held_units[r] + op.amt[r];
          end
          OP_SUB: begin
            for (int r = 0; r < RESOURCES; r++) held_units[r] <= held_units[r] - op.amt[r];
          end
          OP_SETMAX: begin
            max_claim <= op.amt;
          end
          default: ;
        endcase
      end
      if (op.clr_done) begin
        done <= 1'b0;
      end else if (tok_in.valid && fits) begin
        done <= 1'b1;
      end
      tok_out.valid    <= tok_in.valid;
      tok_out.progress <= tok_in.progress | (tok_in.valid & fits);
      for (int r = 0; r < RESOURCES; r++) begin
        tok_out.work[r] <= fits ? tok_in.work[r] + WORK_W'(held_units[r]) : tok_in.work[r];
      end
    end
  end

endmodule

// ===== rtl/core/deadlock_avoiding_resource_allocator.sv =====
// ----------------------------------------------------------------------------
// deadlock_avoiding_resource_allocator
// Banker's-algorithm allocator built as a ring of customer cells.
// ----------------------------------------------------------------------------
// channel   signals                         direction
// command   start, item / busy              in / out
// result    result_valid, result            out
// config    cfg_valid, cfg_index, cfg_data / cfg_ready   in / out
//
// Release, claim, refused commands and requests failing need or availability
// go from S_EVAL straight to S_RESP, which gives the result beat.
// Requests that run the safety check go through S_LAUNCH and S_RUN; the token
// makes from 1 to CUSTOMERS + 1 passes and walks one cell per cycle.
// Synchronous reset clears all claims, holdings and totals.
// The result beat lasts one cycle; busy stays high until after it.
// ----------------------------------------------------------------------------
module deadlock_avoiding_resource_allocator import dara_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  output logic       result_valid,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  fsm_state_t state, state_next;
  item_t      item_q;
  logic [2:0] status, status_next;
  logic [RESOURCES-1:0][7:0] total, alloc, alloc_next, avail, amt;
  logic [CUSTOMERS-1:0][RESOURCES-1:0][7:0] cell_max, cell_held;
  logic [CUSTOMERS-1:0] cell_done;
  token_t chain [CUSTOMERS+1];
  cell_op_t op;
  logic [CIDX_W+2:0] cust_ext;
  logic [CIDX_W-1:0] sel;
  logic in_range, need_fail, avail_fail, held_fail, claim_fail;
  logic launch, reinject, finish;
  logic [7:0] sel_need;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  assign cust_ext = {{CIDX_W{1'b0}}, item_q.customer};
  assign sel      = cust_ext[CIDX_W-1:0];
  assign in_range = (int'(item_q.customer) < CUSTOMERS);

  always_comb begin
    logic [7:0] amt_all [4];
    amt_all[0] = item_q.amount_0;
    amt_all[1] = item_q.amount_1;
    amt_all[2] = item_q.amount_2;
    amt_all[3] = item_q.amount_3;
    for (int r = 0; r < RESOURCES; r++) begin
      amt[r]   = amt_all[r];
      avail[r] = (total[r] > alloc[r]) ? total[r] - alloc[r] : 8'd0;
    end
  end

  always_comb begin
    need_fail  = 1'b0;
    avail_fail = 1'b0;
    held_fail  = 1'b0;
    claim_fail = 1'b0;
    sel_need   = '0;
    for (int r = 0; r < RESOURCES; r++) begin
      sel_need = (cell_max[sel][r] > cell_held[sel][r]) ?
                 cell_max[sel][r] - cell_held[sel][r] : 8'd0;
      if (amt[r] > sel_need)          need_fail  = 1'b1;
      if (amt[r] > avail[r])          avail_fail = 1'b1;
      if (amt[r] > cell_held[sel][r]) held_fail  = 1'b1;
      if (cell_held[sel][r] != 8'd0)  claim_fail = 1'b1;
    end
  end

  assign launch   = (state == S_LAUNCH);
  assign reinject = chain[CUSTOMERS].valid &  chain[CUSTOMERS].progress;
  assign finish   = chain[CUSTOMERS].valid & ~chain[CUSTOMERS].progress;

  always_comb begin
    chain[0] = '0;
    if (launch) begin
      chain[0].valid = 1'b1;
      for (int r = 0; r < RESOURCES; r++) chain[0].work[r] = WORK_W'(avail[r]);
    end else if (reinject) begin
      chain[0].valid = 1'b1;
      chain[0].work  = chain[CUSTOMERS].work;
    end
  end

  for (genvar i = 0; i < CUSTOMERS; i++) begin : g_cell
    dara_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .id         (CIDX_W'(i)),
      .op         (op),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1]),
      .max_claim  (cell_max[i]),
      .held_units (cell_held[i]),
      .done       (cell_done[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_EVAL;
      S_EVAL: begin
        if (in_range && item_q.cmd == CMD_REQUEST && !need_fail && !avail_fail)
          state_next = S_LAUNCH;
        else
          state_next = S_RESP;
      end
      S_LAUNCH: state_next = S_RUN;
      S_RUN:    if (finish) state_next = S_RESP;
      S_RESP:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op          = '0;
    op.code     = OP_NONE;
    op.sel      = sel;
    op.amt      = amt;
    status_next = status;
    alloc_next  = alloc;
    case (state)
      S_EVAL: begin
        if (!in_range) begin
          status_next = STAT_REFUSED;
        end else begin
          case (item_q.cmd)
            CMD_REQUEST: begin
              if (need_fail) status_next = STAT_NEED;
              else if (avail_fail) status_next = STAT_AVAIL;
              else begin
                op.code     = OP_ADD;
                op.clr_done = 1'b1;
                for (int r = 0; r < RESOURCES; r++) alloc_next[r] = alloc[r] + amt[r];
              end
            end
            CMD_RELEASE: begin
              if (held_fail) status_next = STAT_HELD;
              else begin
                op.code     = OP_SUB;
                status_next = STAT_DONE;
                for (int r = 0; r < RESOURCES; r++)
                  alloc_next[r] = (alloc[r] >= amt[r]) ? alloc[r] - amt[r] : 8'd0;
              end
            end
            CMD_CLAIM: begin
              if (claim_fail) status_next = STAT_REFUSED;
              else begin
                op.code     = OP_SETMAX;
                status_next = STAT_DONE;
              end
            end
            default: status_next = STAT_REFUSED;
          endcase
        end
      end
      S_RUN: begin
        if (finish) begin
          if (&cell_done) status_next = STAT_DONE;
          else begin
            status_next = STAT_UNSAFE;
            op.code     = OP_SUB;
            for (int r = 0; r < RESOURCES; r++) alloc_next[r] = alloc[r] - amt[r];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      alloc <= '0;
    end else begin
      state <= state_next;
      alloc <= alloc_next;
      if (cfg_valid && cfg_ready) begin
        for (int r = 0; r < RESOURCES; r++)
          if (int'(cfg_index) == r) total[r] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    if (start && !busy) item_q <= item;
  end

  always_comb begin
    logic [7:0] av [4];
    for (int r = 0; r < 4; r++) av[r] = 8'd0;
    for (int r = 0; r < RESOURCES; r++) av[r] = avail[r];
    result_valid   = (state == S_RESP);
    result.status  = status;
    result.avail_0 = av[0];
    result.avail_1 = av[1];
    result.avail_2 = av[2];
    result.avail_3 = av[3];
  end

endmodule

// ===== rtl/core/dara_checker.sv =====
// ----------------------------------------------------------------------------
// dara_checker
// Port-level checks of the allocator's command and result channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dara_checker import dara_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    result_valid,
  input result_t result
);

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPLY(a_beat_busy, clk, rst, result_valid, busy)
  `ASSERT_NEXT(a_beat_single, clk, rst, result_valid, !result_valid && !busy)
  `ASSERT_IMPLY(a_status_code, clk, rst, result_valid, result.status <= STAT_REFUSED)

endmodule

bind deadlock_avoiding_resource_allocator dara_checker u_dara_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
